// ===== rtl/mpp_pkg.sv =====
// Shared types, constants and arctangent tables of the map point projector.
`default_nettype none
package mpp_pkg;

    localparam int MERC_ITERATIONS = 24;
    localparam int FRAC_BITS       = 40;
    localparam int MERC_FRAC       = 16;
    localparam int NORM_CELLS      = 6;

    localparam logic signed [63:0] Q60_ONE  = 64'sh1000000000000000;
    localparam logic signed [63:0] PI_Q60   = 64'sh3243F6A8885A308D;
    localparam logic signed [63:0] PI_QTR   = PI_Q60 >>> 2;
    localparam logic signed [63:0] LN2_Q60  = 64'sh0B17217F7D1CF79B;
    localparam logic signed [63:0] HALF_RAD =
        (PI_Q60 + 64'sd1800000000) / 64'sd3600000000;
    localparam logic [45:0]        DEG7_Q16  = 46'd37549362061694;
    localparam logic signed [30:0] LAT_CLAMP = 31'sd850511288;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_MODE     = 3'd0,
        REG_LNG_REF  = 3'd1,
        REG_LAT_REF  = 3'd2,
        REG_GAIN_X   = 3'd3,
        REG_GAIN_Z   = 3'd4,
        REG_OFFSET_Z = 3'd5
    } cfg_reg_t;

    // Data that rides along the cell row untouched
    typedef struct packed {
        logic               mode;
        logic signed [32:0] dlng;
        logic signed [31:0] dlat;
    } side_t;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        side_t              side;
    } circ_t;

    typedef struct packed {
        logic signed [63:0] s;
        logic signed [63:0] c;
        logic signed [3:0]  k;
        side_t              side;
    } norm_t;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [3:0]  k;
        side_t              side;
    } hyp_t;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } sat_t;

    typedef logic [63:0][63:0] tab_t;

    // Restoring division, elaboration only
    function automatic logic [63:0] udiv_small(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Truncated power series of atan / atanh of 2^-i in Q60
    function automatic logic signed [63:0] series_q60(input int i, input bit alt);
        logic signed [63:0] s;
        logic [63:0]        t;
        int                 e;
        s = '0;
        for (int k = 0; k <= 30; k++)
        begin
            e = i * (2 * k + 1);
            if (e <= 60)
            begin
                t = udiv_small(64'd1 << (60 - e), 64'(2 * k + 1));
                if (alt && k[0])
                    s = s - $signed(t);
                else
                    s = s + $signed(t);
            end
        end
        return s;
    endfunction

    function automatic tab_t build_tab(input bit hyp);
        tab_t tb;
        tb[0] = hyp ? 64'd0 : PI_QTR;
        for (int i = 1; i < 64; i++)
            tb[i] = series_q60(i, !hyp);
        return tb;
    endfunction

    localparam tab_t ATAN_TAB  = build_tab(1'b0);
    localparam tab_t ATANH_TAB = build_tab(1'b1);

    function automatic int hyp_count();
        int n;
        n = 0;
        for (int i = 1; i <= MERC_ITERATIONS; i++)
            n += (i == 4 || i == 13 || i == 40) ? 2 : 1;
        return n;
    endfunction

    localparam int HYP_STEPS = hyp_count();

    // Shift of hyperbolic step j, with steps 4, 13 and 40 done twice
    function automatic logic [5:0] hyp_shift(input int j);
        int          n;
        logic [5:0]  r;
        n = 0;
        r = '0;
        for (int i = 1; i <= MERC_ITERATIONS; i++)
        begin
            if (n == j)
                r = 6'(i);
            n++;
            if (i == 4 || i == 13 || i == 40)
            begin
                if (n == j)
                    r = 6'(i);
                n++;
            end
        end
        return r;
    endfunction

    // Round toward zero by 2^s, clip to 32 bits signed
    function automatic sat_t trunc_sat(input logic signed [99:0] v, input int s);
        logic [99:0] m;
        logic [99:0] q;
        logic        neg;
        logic [31:0] lim;
        sat_t        r;
        neg   = v[99];
        m     = neg ? (~$unsigned(v) + 100'd1) : $unsigned(v);
        q     = m >> s;
        lim   = neg ? 32'h80000000 : 32'h7FFFFFFF;
        r.sat = (q > {68'd0, lim});
        r.val = r.sat ? lim : q[31:0];
        if (neg)
            r.val = 32'd0 - r.val;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mpp_circ_cell.sv =====
// One circular CORDIC rotation cell of the tangent front end.
`default_nettype none
module mpp_circ_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [5:0]    idx,
    input  wire logic          in_valid,
    input  wire mpp_pkg::circ_t in_data,
    output logic               up_ready,
    output logic               out_valid,
    output mpp_pkg::circ_t     out_data,
    input  wire logic          dn_ready
);

    logic           valid_reg;
    mpp_pkg::circ_t data_reg;
    mpp_pkg::circ_t data_next;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic signed [63:0] ang;

    assign up_ready  = !valid_reg || dn_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Rotate toward zero residual angle
    always_comb
    begin
        dx        = $signed(in_data.y) >>> idx;
        dy        = $signed(in_data.x) >>> idx;
        ang       = $signed(mpp_pkg::ATAN_TAB[idx]);
        data_next = in_data;
        if (!in_data.z[63])
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - ang;
        end
        else
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && in_valid)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ===== rtl/mpp_norm_cell.sv =====
// One range reduction cell: brings sine and cosine within a factor of two.
`default_nettype none
module mpp_norm_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire mpp_pkg::norm_t in_data,
    output logic               up_ready,
    output logic               out_valid,
    output mpp_pkg::norm_t     out_data,
    input  wire logic          dn_ready
);

    logic           valid_reg;
    mpp_pkg::norm_t data_reg;
    mpp_pkg::norm_t data_next;
    logic signed [64:0] s_w;
    logic signed [64:0] c_w;

    assign up_ready  = !valid_reg || dn_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Double the smaller side once, tracking the power of two in k
    always_comb
    begin
        s_w       = {in_data.s[63], in_data.s};
        c_w       = {in_data.c[63], in_data.c};
        data_next = in_data;
        if (s_w > (c_w <<< 1))
        begin
            data_next.c = in_data.c <<< 1;
            data_next.k = in_data.k + 4'sd1;
        end
        else if (c_w > (s_w <<< 1))
        begin
            data_next.s = in_data.s <<< 1;
            data_next.k = in_data.k - 4'sd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && in_valid)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ===== rtl/mpp_hyp_cell.sv =====
// One hyperbolic vectoring cell of the logarithm back end.
`default_nettype none
module mpp_hyp_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [5:0]    idx,
    input  wire logic          in_valid,
    input  wire mpp_pkg::hyp_t in_data,
    output logic               up_ready,
    output logic               out_valid,
    output mpp_pkg::hyp_t      out_data,
    input  wire logic          dn_ready
);

    logic          valid_reg;
    mpp_pkg::hyp_t data_reg;
    mpp_pkg::hyp_t data_next;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic signed [63:0] ang;

    assign up_ready  = !valid_reg || dn_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Drive y toward zero, accumulating atanh in z
    always_comb
    begin
        dx        = $signed(in_data.y) >>> idx;
        dy        = $signed(in_data.x) >>> idx;
        ang       = $signed(mpp_pkg::ATANH_TAB[idx]);
        data_next = in_data;
        if (!in_data.y[63])
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + ang;
        end
        else
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && in_valid)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ===== rtl/map_point_projector_core.sv =====
// Top level of the map point projector: config, cell row and output arithmetic.
// Usage:
//  s_* carries one point per transfer (latitude, longitude in 1e-7 degree);
//  m_* returns grid_x, grid_z and the saturation flag for each point, in order.
//  cfg_we/cfg_index/cfg_data write one register; write only
//  while no point is in flight.
//  Every stage is a register with its own valid bit and a bubble-collapsing
//  ready, so a point is taken every cycle while results keep draining, and
//  empty stages keep filling while m_tready is low.
//  Stages in order: two input stages, the circular CORDIC cells, the range
//  reduction cells, the hyperbolic cells (steps 4 and 13 run twice) and seven
//  multiply, sum and saturate stages.
//  Throughput is one point per cycle while m_tready stays high, set by the one-cell-per-iteration row.
//  When m_tready stays low, the row fills up and s_tready falls once every
//  stage holds a point; nothing is lost.
//  Reset clears all valid bits and sets every configuration register to zero.
`default_nettype none
module map_point_projector_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [30:0] latitude, [62:31] longitude
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [31:0] grid_x, [63:32] grid_z, [64] saturated
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    localparam int NC = mpp_pkg::MERC_ITERATIONS;
    localparam int NN = mpp_pkg::NORM_CELLS;
    localparam int NH = mpp_pkg::HYP_STEPS;
    localparam int NT = 7;

    // Configuration registers
    logic               mode_reg;
    logic signed [31:0] lng_ref_reg;
    logic signed [30:0] lat_ref_reg;
    logic [47:0]        gain_x_reg;
    logic [47:0]        gain_z_reg;
    logic signed [47:0] offset_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            lng_ref_reg  <= '0;
            lat_ref_reg  <= '0;
            gain_x_reg   <= '0;
            gain_z_reg   <= '0;
            offset_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (mpp_pkg::cfg_reg_t'(cfg_index))
                mpp_pkg::REG_MODE:     mode_reg     <= cfg_data[0];
                mpp_pkg::REG_LNG_REF:  lng_ref_reg  <= $signed(cfg_data[31:0]);
                mpp_pkg::REG_LAT_REF:  lat_ref_reg  <= $signed(cfg_data[30:0]);
                mpp_pkg::REG_GAIN_X:   gain_x_reg   <= cfg_data;
                mpp_pkg::REG_GAIN_Z:   gain_z_reg   <= cfg_data;
                mpp_pkg::REG_OFFSET_Z: offset_z_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // Input stages: clamp and differences, then the starting half angle
    logic               f0_v_reg;
    logic               f1_v_reg;
    logic               en_f0;
    logic               en_f1;
    logic signed [30:0] lat_in;
    logic signed [31:0] lng_in;
    logic signed [30:0] lat_c_next;
    logic signed [30:0] f0_lat_c_reg;
    mpp_pkg::side_t     f0_side_reg;
    mpp_pkg::side_t     f0_side_next;
    logic signed [63:0] f1_z_reg;
    mpp_pkg::side_t     f1_side_reg;

    logic [NC:0]        c_valid;
    logic [NC:0]        c_ready;
    mpp_pkg::circ_t     c_data [NC+1];

    assign lat_in   = $signed(s_tdata[30:0]);
    assign lng_in   = $signed(s_tdata[62:31]);
    assign en_f1    = !f1_v_reg || c_ready[0];
    assign en_f0    = !f0_v_reg || en_f1;
    assign s_tready = en_f0;

    always_comb
    begin
        if (lat_in > mpp_pkg::LAT_CLAMP)
            lat_c_next = mpp_pkg::LAT_CLAMP;
        else if (lat_in < -mpp_pkg::LAT_CLAMP)
            lat_c_next = -mpp_pkg::LAT_CLAMP;
        else
            lat_c_next = lat_in;
        f0_side_next.mode = mode_reg;
        f0_side_next.dlng = 33'(lng_in) - 33'(lng_ref_reg);
        f0_side_next.dlat = 32'(lat_in) - 32'(lat_ref_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_v_reg <= 1'b0;
            f1_v_reg <= 1'b0;
        end
        else
        begin
            if (en_f0)
                f0_v_reg <= s_tvalid;
            if (en_f1)
                f1_v_reg <= f0_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_f0 && s_tvalid)
        begin
            f0_lat_c_reg <= lat_c_next;
            f0_side_reg  <= f0_side_next;
        end
        if (en_f1 && f0_v_reg)
        begin
            f1_z_reg    <= mpp_pkg::PI_QTR + 64'(f0_lat_c_reg) * mpp_pkg::HALF_RAD;
            f1_side_reg <= f0_side_reg;
        end
    end

    // Circular rotation cells
    assign c_valid[0]       = f1_v_reg;
    assign c_data[0].x      = mpp_pkg::Q60_ONE;
    assign c_data[0].y      = '0;
    assign c_data[0].z      = f1_z_reg;
    assign c_data[0].side   = f1_side_reg;

    for (genvar j = 0; j < NC; j++)
    begin : g_circ
        mpp_circ_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (6'(j)),
            .in_valid  (c_valid[j]),
            .in_data   (c_data[j]),
            .up_ready  (c_ready[j]),
            .out_valid (c_valid[j+1]),
            .out_data  (c_data[j+1]),
            .dn_ready  (c_ready[j+1])
        );
    end

    // Range reduction cells, sine and cosine raised to one if not positive
    logic [NN:0]    n_valid;
    logic [NN:0]    n_ready;
    mpp_pkg::norm_t n_data [NN+1];

    assign n_valid[0]     = c_valid[NC];
    assign c_ready[NC]    = n_ready[0];
    assign n_data[0].s    = (c_data[NC].y < 64'sd1) ? 64'sd1 : c_data[NC].y;
    assign n_data[0].c    = (c_data[NC].x < 64'sd1) ? 64'sd1 : c_data[NC].x;
    assign n_data[0].k    = '0;
    assign n_data[0].side = c_data[NC].side;

    for (genvar j = 0; j < NN; j++)
    begin : g_norm
        mpp_norm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (n_valid[j]),
            .in_data   (n_data[j]),
            .up_ready  (n_ready[j]),
            .out_valid (n_valid[j+1]),
            .out_data  (n_data[j+1]),
            .dn_ready  (n_ready[j+1])
        );
    end

    // Hyperbolic vectoring cells on S + C and S - C
    logic [NH:0]   h_valid;
    logic [NH:0]   h_ready;
    mpp_pkg::hyp_t h_data [NH+1];

    assign h_valid[0]     = n_valid[NN];
    assign n_ready[NN]    = h_ready[0];
    assign h_data[0].x    = n_data[NN].s + n_data[NN].c;
    assign h_data[0].y    = n_data[NN].s - n_data[NN].c;
    assign h_data[0].z    = '0;
    assign h_data[0].k    = n_data[NN].k;
    assign h_data[0].side = n_data[NN].side;

    for (genvar j = 0; j < NH; j++)
    begin : g_hyp
        mpp_hyp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (mpp_pkg::hyp_shift(j)),
            .in_valid  (h_valid[j]),
            .in_data   (h_data[j]),
            .up_ready  (h_ready[j]),
            .out_valid (h_valid[j+1]),
            .out_data  (h_data[j+1]),
            .dn_ready  (h_ready[j+1])
        );
    end

    // Output stages: handshake
    logic [NT-1:0] t_v_reg;
    logic [NT:0]   t_en;

    always_comb
    begin
        t_en[NT] = m_tready;
        for (int k = NT - 1; k >= 0; k--)
            t_en[k] = !t_v_reg[k] || t_en[k+1];
    end

    assign h_ready[NH] = t_en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_v_reg <= '0;
        else
        begin
            if (t_en[0])
                t_v_reg[0] <= h_valid[NH];
            for (int k = 1; k < NT; k++)
                if (t_en[k])
                    t_v_reg[k] <= t_v_reg[k-1];
        end
    end

    // Output stages: data
    logic signed [63:0]  lsum;
    logic [63:0]         t0_la_reg;
    logic                t0_lneg_reg;
    logic signed [57:0]  t0_px_lo_reg;
    logic signed [57:0]  t0_px_hi_reg;
    mpp_pkg::side_t      t0_side_reg;
    logic [54:0]         t1_p00_reg;
    logic [54:0]         t1_p01_reg;
    logic [54:0]         t1_p10_reg;
    logic [54:0]         t1_p11_reg;
    logic signed [81:0]  t1_xw_reg;
    logic                t1_lneg_reg;
    mpp_pkg::side_t      t1_side_reg;
    logic [109:0]        prod_l;
    logic [49:0]         t2_mm_reg;
    logic signed [81:0]  t2_xw_reg;
    logic                t2_lneg_reg;
    mpp_pkg::side_t      t2_side_reg;
    logic signed [50:0]  t3_t_reg;
    logic signed [81:0]  t3_xw_reg;
    logic [49:0]         t4_q00_reg;
    logic [49:0]         t4_q01_reg;
    logic signed [49:0]  t4_q10_reg;
    logic signed [49:0]  t4_q11_reg;
    logic signed [81:0]  t4_xw_reg;
    logic [99:0]         prod_z;
    logic signed [99:0]  zw;
    logic signed [99:0]  t5_zw_reg;
    mpp_pkg::sat_t       t5_x_reg;
    mpp_pkg::sat_t       sat_z;
    logic [31:0]         out_x_reg;
    logic [31:0]         out_z_reg;
    logic                out_sat_reg;

    assign lsum = 64'(h_data[NH].k * mpp_pkg::LN2_Q60) + (h_data[NH].z <<< 1);
    assign prod_l = 110'(t1_p00_reg) + (110'(t1_p01_reg) << 23)
                  + (110'(t1_p10_reg) << 32) + (110'(t1_p11_reg) << 55);
    assign prod_z = 100'(t4_q00_reg) + (100'(t4_q01_reg) << 24)
                  + (100'(t4_q10_reg) << 26) + (100'(t4_q11_reg) << 50);
    assign zw     = (100'(offset_z_reg) <<< mpp_pkg::FRAC_BITS) - $signed(prod_z);
    assign sat_z  = mpp_pkg::trunc_sat(t5_zw_reg, mpp_pkg::FRAC_BITS + mpp_pkg::MERC_FRAC);

    always_ff @(posedge clk)
    begin
        // log magnitude and longitude partial products
        if (t_en[0] && h_valid[NH])
        begin
            t0_la_reg    <= lsum[63] ? (64'd0 - $unsigned(lsum)) : $unsigned(lsum);
            t0_lneg_reg  <= lsum[63];
            t0_px_lo_reg <= h_data[NH].side.dlng * $signed({1'b0, gain_x_reg[23:0]});
            t0_px_hi_reg <= h_data[NH].side.dlng * $signed({1'b0, gain_x_reg[47:24]});
            t0_side_reg  <= h_data[NH].side;
        end
        // degree scale partials, easting sum
        if (t_en[1] && t_v_reg[0])
        begin
            t1_p00_reg  <= t0_la_reg[31:0]  * mpp_pkg::DEG7_Q16[22:0];
            t1_p01_reg  <= t0_la_reg[31:0]  * mpp_pkg::DEG7_Q16[45:23];
            t1_p10_reg  <= t0_la_reg[63:32] * mpp_pkg::DEG7_Q16[22:0];
            t1_p11_reg  <= t0_la_reg[63:32] * mpp_pkg::DEG7_Q16[45:23];
            t1_xw_reg   <= 82'(t0_px_lo_reg) + (82'(t0_px_hi_reg) <<< 24);
            t1_lneg_reg <= t0_lneg_reg;
            t1_side_reg <= t0_side_reg;
        end
        // Mercator magnitude in Q16
        if (t_en[2] && t_v_reg[1])
        begin
            t2_mm_reg   <= prod_l[109:60];
            t2_xw_reg   <= t1_xw_reg;
            t2_lneg_reg <= t1_lneg_reg;
            t2_side_reg <= t1_side_reg;
        end
        // northing term by mode
        if (t_en[3] && t_v_reg[2])
        begin
            if (t2_side_reg.mode)
                t3_t_reg <= t2_lneg_reg ? -$signed({1'b0, t2_mm_reg})
                                        : $signed({1'b0, t2_mm_reg});
            else
                t3_t_reg <= 51'(t2_side_reg.dlat) <<< mpp_pkg::MERC_FRAC;
            t3_xw_reg <= t2_xw_reg;
        end
        // northing partial products
        if (t_en[4] && t_v_reg[3])
        begin
            t4_q00_reg <= t3_t_reg[25:0] * gain_z_reg[23:0];
            t4_q01_reg <= t3_t_reg[25:0] * gain_z_reg[47:24];
            t4_q10_reg <= $signed(t3_t_reg[50:26]) * $signed({1'b0, gain_z_reg[23:0]});
            t4_q11_reg <= $signed(t3_t_reg[50:26]) * $signed({1'b0, gain_z_reg[47:24]});
            t4_xw_reg  <= t3_xw_reg;
        end
        // northing sum, easting saturate
        if (t_en[5] && t_v_reg[4])
        begin
            t5_zw_reg <= zw;
            t5_x_reg  <= mpp_pkg::trunc_sat(100'(t4_xw_reg), mpp_pkg::FRAC_BITS);
        end
        // output register
        if (t_en[6] && t_v_reg[5])
        begin
            out_x_reg   <= t5_x_reg.val;
            out_z_reg   <= sat_z.val;
            out_sat_reg <= t5_x_reg.sat || sat_z.sat;
        end
    end

    assign m_tvalid = t_v_reg[NT-1];
    assign m_tdata  = {7'd0, out_sat_reg, out_z_reg, out_x_reg};

    // A clipped result sits at one of the 32-bit limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_sat_reg |->
            (out_x_reg == 32'h7FFFFFFF || out_x_reg == 32'h80000000 ||
             out_z_reg == 32'h7FFFFFFF || out_z_reg == 32'h80000000))
        else $error("saturated flag without a clipped coordinate");

    // An empty input stage never refuses a transfer
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !f0_v_reg |-> s_tready)
        else $error("input refused with empty first stage");

    // An accepted point occupies the first stage next cycle
    a_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> f0_v_reg)
        else $error("accepted point lost at input stage");

    // Output register drained or idle lets the last stage advance
    a_tail_move: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> t_en[NT-1])
        else $error("output stage stuck while receiver ready");

endmodule
`default_nettype wire
